FILE: design/bsa_pkg.sv
package bsa_pkg;

    localparam int MAX_SLOTS_DEF = 1024;
    localparam int WORD_BITS     = 64;
    localparam int BIT_W         = 6;
    localparam int PAGE_SHIFT    = 12;                 // 4096-byte pages
    localparam int SIZE_W        = 32;
    localparam int PAGES_W       = SIZE_W - PAGE_SHIFT + 1;
    localparam int CFG_CNT_W     = 11;
    localparam int IDX_W         = 10;
    localparam int STATUS_W      = 3;
    localparam int OFFSET_W      = 42;
    localparam int COMMIT_W      = 43;
    localparam int USED_W        = 11;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_CNT_W-1:0] SLOT_LIMIT_RST = 11'd1024;
    localparam logic [SIZE_W-1:0]    SLOT_BYTES_RST = 32'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_BAD_SIZE     = 3'd1,
        ST_NO_FREE      = 3'd2,
        ST_NOT_IN_USE   = 3'd3,
        ST_OUT_OF_RANGE = 3'd4
    } bsa_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ALLOC,
        S_REL,
        S_OUT
    } bsa_state_t;

    typedef struct packed {
        logic [CFG_CNT_W-1:0] slot_limit;
        logic [SIZE_W-1:0]    slot_bytes;
    } bsa_cfg_t;

    typedef struct packed {
        logic              mode;
        logic [SIZE_W-1:0] req_bytes;
        logic [IDX_W-1:0]  slot_index;
    } bsa_item_t;

    typedef struct packed {
        bsa_status_t         status;
        logic [IDX_W-1:0]    granted_index;
        logic [OFFSET_W-1:0] slot_offset;
        logic [COMMIT_W-1:0] committed_bytes;
        logic [USED_W-1:0]   slots_in_use;
    } bsa_result_t;

endpackage

FILE: design/bsa_ram.sv
module bsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: design/bsa_word_find.sv
// Bitmap word as the search sees it: slots at or past the count read as used.
module bsa_word_find #(
    parameter int WA_W  = 4,
    parameter int CNT_W = 11
) (
    input  logic [bsa_pkg::WORD_BITS-1:0] word,
    input  logic [WA_W-1:0]               addr,
    input  logic [CNT_W-1:0]              count,
    output logic                          full,
    output logic [bsa_pkg::BIT_W-1:0]     bit_pos
);
    import bsa_pkg::*;

    logic [31:0]          first;
    logic [31:0]          cnt;
    logic [31:0]          rem;
    logic [WORD_BITS-1:0] in_range;
    logic [WORD_BITS-1:0] seen;
    logic [WORD_BITS-1:0] lowest;

    assign first = 32'(addr) << BIT_W;
    assign cnt   = 32'(count);
    assign rem   = cnt - first;

    always_comb
    begin
        if (first >= cnt)
        begin
            in_range = '0;
        end
        else if (rem >= 32'(WORD_BITS))
        begin
            in_range = '1;
        end
        else
        begin
            in_range = (WORD_BITS'(1) << rem[BIT_W-1:0]) - WORD_BITS'(1);
        end
    end

    assign seen   = word | ~in_range;
    assign full   = &seen;
    // one-hot of the lowest clear bit
    assign lowest = ~seen & (seen + WORD_BITS'(1));

    always_comb
    begin
        bit_pos = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (lowest[i])
            begin
                bit_pos = bit_pos | BIT_W'(i);
            end
        end
    end

endmodule

FILE: design/bsa_ctrl.sv
module bsa_ctrl #(
    parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bsa_pkg::bsa_cfg_t    cfg,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  bsa_pkg::bsa_item_t   item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output bsa_pkg::bsa_result_t res
);
    import bsa_pkg::*;

    localparam int NWORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int PG_AW  = $clog2(NWORDS * WORD_BITS);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam logic [WA_W-1:0] LAST_WORD = WA_W'(NWORDS - 1);

    bsa_state_t          state_reg, state_next;
    logic [WA_W-1:0]     hint_reg, hint_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [COMMIT_W-1:0] committed_reg, committed_next;
    logic [NWORDS-1:0]   valid_reg, valid_next;

    logic [WA_W-1:0]      addr_reg, addr_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [PAGES_W-1:0]   pages_reg, pages_next;
    logic [PG_AW-1:0]     slot_reg, slot_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    bsa_status_t          status_reg, status_next;
    logic [IDX_W-1:0]     granted_reg, granted_next;
    logic [OFFSET_W-1:0]  offset_reg, offset_next;

    logic [CNT_W-1:0]     eff_count;
    logic                 accept;
    logic                 bad_size;
    logic                 out_of_range;
    logic [WA_W-1:0]      idx_word;
    logic [PAGES_W-1:0]   item_pages;

    logic                 bm_wr_en;
    logic [WA_W-1:0]      bm_rd_addr;
    logic [WORD_BITS-1:0] bm_wr_data;
    logic [WORD_BITS-1:0] bm_rd_data;
    logic [WORD_BITS-1:0] bm_word;
    logic                 pg_wr_en;
    logic [PG_AW-1:0]     pg_rd_addr;
    logic [PAGES_W-1:0]   pg_rd_data;

    logic                 wf_full;
    logic [BIT_W-1:0]     wf_bit;
    logic [31:0]          slot_wide;
    logic [63:0]          offset_prod;

    assign eff_count = CNT_W'((32'(cfg.slot_limit) > 32'(MAX_SLOTS))
                              ? 32'(MAX_SLOTS) : 32'(cfg.slot_limit));

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign bad_size     = (item.req_bytes == '0) || (item.req_bytes > cfg.slot_bytes);
    assign out_of_range = (32'(item.slot_index) >= 32'(eff_count));
    assign idx_word     = WA_W'(32'(item.slot_index) >> BIT_W);
    assign item_pages   = PAGES_W'(({1'b0, item.req_bytes} + 33'((1 << PAGE_SHIFT) - 1))
                                   >> PAGE_SHIFT);

    // a word never written since reset reads as all free
    assign bm_word = valid_reg[addr_reg] ? bm_rd_data : '0;

    assign slot_wide   = 32'(slot_reg);
    assign offset_prod = slot_wide * cfg.slot_bytes;

    bsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (bm_wr_en),
        .wr_addr (addr_reg),
        .wr_data (bm_wr_data),
        .rd_addr (bm_rd_addr),
        .rd_data (bm_rd_data)
    );

    bsa_ram #(
        .WIDTH (PAGES_W),
        .DEPTH (NWORDS * WORD_BITS)
    ) u_pages (
        .clk     (clk),
        .wr_en   (pg_wr_en),
        .wr_addr (slot_reg),
        .wr_data (pages_reg),
        .rd_addr (pg_rd_addr),
        .rd_data (pg_rd_data)
    );

    bsa_word_find #(
        .WA_W  (WA_W),
        .CNT_W (CNT_W)
    ) u_find (
        .word    (bm_word),
        .addr    (addr_reg),
        .count   (eff_count),
        .full    (wf_full),
        .bit_pos (wf_bit)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!item.mode)
                    begin
                        state_next = bad_size ? S_OUT : S_SCAN;
                    end
                    else
                    begin
                        state_next = out_of_range ? S_OUT : S_REL;
                    end
                end
            end
            S_SCAN:
            begin
                if (!wf_full)
                begin
                    state_next = S_ALLOC;
                end
                else if (addr_reg == LAST_WORD)
                begin
                    state_next = S_OUT;
                end
            end
            S_ALLOC: state_next = S_OUT;
            S_REL:   state_next = S_OUT;
            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        hint_next      = hint_reg;
        used_next      = used_reg;
        committed_next = committed_reg;
        valid_next     = valid_reg;
        addr_next      = addr_reg;
        idx_next       = idx_reg;
        pages_next     = pages_reg;
        slot_next      = slot_reg;
        word_next      = word_reg;
        bit_next       = bit_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        offset_next    = offset_reg;
        bm_wr_en       = 1'b0;
        bm_wr_data     = bm_word;
        bm_rd_addr     = addr_reg;
        pg_wr_en       = 1'b0;
        pg_rd_addr     = PG_AW'(32'(item.slot_index));
        res_valid      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                bm_rd_addr = item.mode ? idx_word : hint_reg;
                if (accept)
                begin
                    addr_next    = item.mode ? idx_word : hint_reg;
                    idx_next     = item.slot_index;
                    pages_next   = item_pages;
                    status_next  = ST_OK;
                    granted_next = '0;
                    offset_next  = '0;
                    if (!item.mode && bad_size)
                    begin
                        status_next = ST_BAD_SIZE;
                    end
                    else if (item.mode && out_of_range)
                    begin
                        status_next = ST_OUT_OF_RANGE;
                    end
                end
            end
            S_SCAN:
            begin
                // next word is fetched while this one is examined
                bm_rd_addr = (addr_reg == LAST_WORD) ? addr_reg : addr_reg + 1'b1;
                if (!wf_full)
                begin
                    slot_next = PG_AW'((32'(addr_reg) << BIT_W) | 32'(wf_bit));
                    bit_next  = wf_bit;
                    word_next = bm_word;
                end
                else if (addr_reg == LAST_WORD)
                begin
                    status_next = ST_NO_FREE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_ALLOC:
            begin
                bm_wr_en             = 1'b1;
                bm_wr_data           = word_reg | (WORD_BITS'(1) << bit_reg);
                pg_wr_en             = 1'b1;
                valid_next[addr_reg] = 1'b1;
                hint_next            = addr_reg;
                used_next            = used_reg + 1'b1;
                committed_next       = committed_reg
                                       + (COMMIT_W'(pages_reg) << PAGE_SHIFT);
                granted_next         = IDX_W'(slot_wide);
                offset_next          = OFFSET_W'(offset_prod);
            end
            S_REL:
            begin
                if (!bm_word[idx_reg[BIT_W-1:0]])
                begin
                    status_next = ST_NOT_IN_USE;
                end
                else
                begin
                    bm_wr_en             = 1'b1;
                    bm_wr_data           = bm_word & ~(WORD_BITS'(1) << idx_reg[BIT_W-1:0]);
                    valid_next[addr_reg] = 1'b1;
                    used_next            = used_reg - 1'b1;
                    committed_next       = committed_reg
                                           - (COMMIT_W'(pg_rd_data) << PAGE_SHIFT);
                    if (addr_reg < hint_reg)
                    begin
                        hint_next = addr_reg;
                    end
                end
            end
            S_OUT:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hint_reg      <= '0;
            used_reg      <= '0;
            committed_reg <= '0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            used_reg      <= used_next;
            committed_reg <= committed_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        idx_reg     <= idx_next;
        pages_reg   <= pages_next;
        slot_reg    <= slot_next;
        word_reg    <= word_next;
        bit_reg     <= bit_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        offset_reg  <= offset_next;
    end

    assign res.status          = status_reg;
    assign res.granted_index   = granted_reg;
    assign res.slot_offset     = offset_reg;
    assign res.committed_bytes = committed_reg;
    assign res.slots_in_use    = USED_W'(used_reg);

endmodule

FILE: design/bitmap_slot_allocator.sv
// Slot allocator over a bitmap of 64-bit words, with a search hint.
// Input stream (s_*): tuser = mode (0 allocate, 1 release); tdata carries
// req_bytes and slot_index. Each input word yields exactly one output word.
// Output stream (m_*): tuser = status; tdata carries granted_index,
// slot_offset, committed_bytes and slots_in_use.
// Config channel (cfg_*): index 0 = slot_limit, 1 = slot_bytes; always ready,
// write only while no item is in flight.
// Allocate scans bitmap words from the hint, and the bitmap memory delivers
// one word per cycle. One item at a time: the next word is taken in the
// cycle after the previous result is handed to the output register.
// Reset: config returns to slot_limit 1024, slot_bytes 65536; the bitmap reads
// as all free at once through per-word valid flops, so there is no clearing
// pass. Committed pages per slot need no clear, they are read only for slots
// that were allocated since reset.
// Stall: a result waits in the output register while m_tready is low; the
// block still accepts and works one more word, holding its result until the
// output register frees up.
module bitmap_slot_allocator #(
    parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bsa_pkg::SIZE_W-1:0]      cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [47:0]                     s_tdata,  // req_bytes[31:0], slot_index[41:32]
    input  logic [0:0]                      s_tuser,  // mode[0]
    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [111:0]                    m_tdata,  // granted_index[9:0],
                                                      // slot_offset[51:10],
                                                      // committed_bytes[94:52],
                                                      // slots_in_use[105:95]
    output logic [bsa_pkg::STATUS_W-1:0]    m_tuser   // status[2:0]
);
    import bsa_pkg::*;

    logic [CFG_CNT_W-1:0] slot_limit_reg;
    logic [SIZE_W-1:0]    slot_bytes_reg;

    bsa_cfg_t    cfg;
    bsa_item_t   item;
    bsa_result_t res;
    logic        res_valid;
    logic        res_ready;

    logic                m_tvalid_reg;
    logic [111:0]        m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;

    // config registers: a word is taken every cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_limit_reg <= SLOT_LIMIT_RST;
            slot_bytes_reg <= SLOT_BYTES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SLOT_LIMIT: slot_limit_reg <= CFG_CNT_W'(cfg_data);
                CFG_SLOT_BYTES: slot_bytes_reg <= cfg_data;
                default:        slot_bytes_reg <= slot_bytes_reg;
            endcase
        end
    end

    assign cfg.slot_limit = slot_limit_reg;
    assign cfg.slot_bytes = slot_bytes_reg;

    assign item.mode       = s_tuser[0];
    assign item.req_bytes  = s_tdata[31:0];
    assign item.slot_index = s_tdata[41:32];

    bsa_ctrl #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (s_tvalid),
        .item_ready (s_tready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // output register: loads when empty or when the held word leaves
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_tdata_reg <= {6'b0, res.slots_in_use, res.committed_bytes,
                            res.slot_offset, res.granted_index};
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
